FILE: src/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// shared constants and types for the box frustum culler
// ----------------------------------------------------------------------------
package afc_pkg;

	localparam int PLANE_COUNT = 6;
	localparam int CFG_W = 64;
	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] CFG_MAXDIST = 3'd6;
	localparam logic [22:0] MAXDIST_RESET = 23'h7FFFFF;
	localparam int ROOT_BITS = 26;

	typedef struct packed {
		logic signed [11:0] nx;
		logic signed [11:0] ny;
		logic signed [11:0] nz;
		logic signed [27:0] d;
	} plane_t;

	typedef plane_t [PLANE_COUNT-1:0] plane_arr_t;

endpackage

FILE: src/afc_sqrt.sv
// ----------------------------------------------------------------------------
// afc_sqrt
// pipelined ceiling square root, two result bits per stage plus a round-up stage
// ----------------------------------------------------------------------------
module afc_sqrt (
	input  logic        clk,
	input  logic        adv,
	input  logic [47:0] s_in,
	output logic [25:0] root
);
	localparam int STAGES = afc_pkg::ROOT_BITS / 2;

	logic [25:0] r_q [STAGES+1];
	logic [51:0] rem_q [STAGES+1];
	logic [25:0] root_q;

	always_comb begin
		r_q[0] = '0;
		rem_q[0] = {4'd0, s_in};
	end

	// restoring digit recurrence on remainder; bits 2 per stage
	for (genvar g = 0; g < STAGES; g++) begin : g_st
		localparam int B1 = afc_pkg::ROOT_BITS - 1 - 2 * g;
		localparam int B0 = B1 - 1;
		logic [25:0] r1;
		logic [25:0] r2;
		logic [51:0] t1;
		logic [51:0] t2;
		logic [51:0] rem1;
		always_comb begin
			r1 = r_q[g];
			rem1 = rem_q[g];
			t1 = ({26'd0, r_q[g]} << (B1 + 1)) + (52'd1 << (2 * B1));
			if (t1 <= rem_q[g]) begin
				r1 = r_q[g] | (26'd1 << B1);
				rem1 = rem_q[g] - t1;
			end
			r2 = r1;
			t2 = ({26'd0, r1} << (B0 + 1)) + (52'd1 << (2 * B0));
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (t2 <= rem1) begin
					r_q[g+1] <= r1 | (26'd1 << B0);
					rem_q[g+1] <= rem1 - t2;
				end else begin
					r_q[g+1] <= r2;
					rem_q[g+1] <= rem1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			root_q <= r_q[STAGES] + {25'd0, (rem_q[STAGES] != '0)};
	end

	assign root = root_q;
endmodule

FILE: src/afc_plane.sv
// ----------------------------------------------------------------------------
// afc_plane
// one plane test: products, then sums, then compare, three registered steps
// ----------------------------------------------------------------------------
module afc_plane (
	input  logic                   clk,
	input  logic                   adv,
	input  afc_pkg::plane_t        pl,
	input  logic signed [23:0]     cx,
	input  logic signed [23:0]     cy,
	input  logic signed [23:0]     cz,
	input  logic [22:0]            hx,
	input  logic [22:0]            hy,
	input  logic [22:0]            hz,
	output logic                   cull
);
	logic signed [35:0] pcx_s1, pcy_s1, pcz_s1;
	logic [34:0] phx_s1, phy_s1, phz_s1;
	logic signed [38:0] d_s1;
	logic signed [39:0] s_s2;
	logic [36:0] r_s2;
	logic cull_s3;
	logic signed [34:0] qx, qy, qz;

	always_comb begin
		qx = $signed({1'b0, hx}) * pl.nx;
		qy = $signed({1'b0, hy}) * pl.ny;
		qz = $signed({1'b0, hz}) * pl.nz;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pcx_s1 <= cx * pl.nx;
			pcy_s1 <= cy * pl.ny;
			pcz_s1 <= cz * pl.nz;
			phx_s1 <= qx[34] ? 35'(-qx) : 35'(qx);
			phy_s1 <= qy[34] ? 35'(-qy) : 35'(qy);
			phz_s1 <= qz[34] ? 35'(-qz) : 35'(qz);
			d_s1 <= 39'(pl.d) <<< 10;
			s_s2 <= 40'(d_s1) + 40'(pcx_s1) + 40'(pcy_s1) + 40'(pcz_s1);
			r_s2 <= 37'(phx_s1) + 37'(phy_s1) + 37'(phz_s1);
			cull_s3 <= s_s2 < -$signed({3'd0, r_s2});
		end
	end

	assign cull = cull_s3;
endmodule

FILE: src/aabb_frustum_cull.sv
// ----------------------------------------------------------------------------
// aabb_frustum_cull
// box against view distance and six frustum planes, one beat per cycle
//
// channel   signals                                         dir
// in        in_valid/in_ready, center_*, half_*, cam_dist_sq, item_tag   in
// out       out_valid/out_ready, visible, result_tag        out
// cfg       cfg_we, cfg_idx, cfg_data                       in
//
// one beat per cycle while the output is taken; distance path: squares, sum,
// the 14-stage square root, then limit, limit squared and compare
// planes run in parallel beside it
// reset clears valid bits, planes to zero, max distance to all ones
// the whole pipe holds when the output beat is not taken
// ----------------------------------------------------------------------------
module aabb_frustum_cull (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] center_x,
	input  logic signed [23:0] center_y,
	input  logic signed [23:0] center_z,
	input  logic [22:0]        half_x,
	input  logic [22:0]        half_y,
	input  logic [22:0]        half_z,
	input  logic [47:0]        cam_dist_sq,
	input  logic [15:0]        item_tag,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               visible,
	output logic [15:0]        result_tag,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [63:0]        cfg_data
);
	localparam int SQ_LAT = 14;
	localparam int LAT = SQ_LAT + 5;

	afc_pkg::plane_arr_t planes_q;
	logic [22:0] maxd_q;
	logic [LAT-1:0] vld_q;
	logic adv;

	assign adv = !vld_q[LAT-1] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planes_q <= '0;
			maxd_q <= afc_pkg::MAXDIST_RESET;
		end else if (cfg_we) begin
			if (cfg_idx < 3'(afc_pkg::PLANE_COUNT))
				planes_q[cfg_idx] <= afc_pkg::plane_t'(cfg_data);
			else if (cfg_idx == afc_pkg::CFG_MAXDIST)
				maxd_q <= cfg_data[22:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	// squares of half extents, then their sum
	logic [45:0] sx_s1, sy_s1, sz_s1;
	logic [47:0] ssum_s2;
	logic [25:0] root;
	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s1 <= half_x * half_x;
			sy_s1 <= half_y * half_y;
			sz_s1 <= half_z * half_z;
			ssum_s2 <= 48'(sx_s1) + 48'(sy_s1) + 48'(sz_s1);
		end
	end

	afc_sqrt u_sqrt (
		.clk(clk), .adv(adv), .s_in(ssum_s2), .root(root)
	);

	// root is the square root output that feeds lim_s17
	logic [26:0] lim_s17;
	logic [53:0] limsq_s18;
	logic [47:0] dsq_d [LAT-1];
	logic [15:0] tag_d [LAT];
	logic dist_cull;

	always_ff @(posedge clk) begin
		if (adv) begin
			dsq_d[0] <= cam_dist_sq;
			tag_d[0] <= item_tag;
			for (int i = 1; i < LAT - 1; i++)
				dsq_d[i] <= dsq_d[i-1];
			for (int i = 1; i < LAT; i++)
				tag_d[i] <= tag_d[i-1];
			lim_s17 <= 27'(maxd_q) + 27'(root);
			limsq_s18 <= lim_s17 * lim_s17;
		end
	end
	assign dist_cull = {6'd0, dsq_d[LAT-2]} > limsq_s18;

	// plane tests, delayed to line up with the distance compare
	logic [afc_pkg::PLANE_COUNT-1:0] pc;
	for (genvar p = 0; p < afc_pkg::PLANE_COUNT; p++) begin : g_pl
		afc_plane u_pl (
			.clk(clk), .adv(adv), .pl(planes_q[p]),
			.cx(center_x), .cy(center_y), .cz(center_z),
			.hx(half_x), .hy(half_y), .hz(half_z), .cull(pc[p])
		);
	end

	logic pcull_d [LAT-4];
	always_ff @(posedge clk) begin
		if (adv) begin
			pcull_d[0] <= |pc;
			for (int i = 1; i < LAT - 4; i++)
				pcull_d[i] <= pcull_d[i-1];
		end
	end

	logic vis_q;
	always_ff @(posedge clk) begin
		if (adv)
			vis_q <= !(dist_cull || pcull_d[LAT-5]);
	end

	assign out_valid = vld_q[LAT-1];
	assign visible = vis_q;
	assign result_tag = tag_d[LAT-1];

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_tag) && $stable(visible))
		else $error("output beat changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("pipe stalled with empty output");
	a_vld_move: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted beat lost");
endmodule
